@@ hw/rtl/lpp_pkg.sv @@
// Shared types, constants and functions of the polar-to-pixel converter.
package lpp_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int COORD_BITS_DEF    = 16;
    localparam int MAX_STAGES        = 24;

    localparam int X_W = 36;   // CORDIC x/y width, pixels with 10 fraction bits
    localparam int Z_W = 33;   // residual angle, radians in Q2.30

    localparam logic [14:0] ANG_FULL     = 15'd23040;
    localparam logic [14:0] ANG_QUARTER  = 15'd5760;
    localparam logic [14:0] ANG_HALF     = 15'd11520;
    localparam logic [14:0] ANG_3QUARTER = 15'd17280;
    localparam logic [31:0] ANG_TO_RAD   = 32'd292818;
    localparam logic [29:0] INV_GAIN     = 30'd652032874;

    localparam logic [23:0] SCALE_RESET  = 24'd65536;
    localparam logic [11:0] CENTRE_X_RST = 12'd400;
    localparam logic [11:0] CENTRE_Y_RST = 12'd300;

    typedef enum logic [1:0] {
        REG_PIXEL_SCALE = 2'd0,
        REG_CENTRE_X    = 2'd1,
        REG_CENTRE_Y    = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // One CORDIC pipeline slot: the rotating vector plus the passenger fields.
    typedef struct packed {
        logic                  valid;
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] y;
        logic signed [Z_W-1:0] z;
        quad_t                 quad;
        logic [5:0]            qual;
        logic                  start;
    } cordic_t;

    // atan(2^-i) in Q2.30, rounded.
    function automatic logic signed [Z_W-1:0] atan_q30(input int i);
        logic signed [Z_W-1:0] r;
        case (i)
            0:       r = 33'sd843314857;
            1:       r = 33'sd497837829;
            2:       r = 33'sd263043837;
            3:       r = 33'sd133525159;
            4:       r = 33'sd67021687;
            5:       r = 33'sd33543516;
            6:       r = 33'sd16775851;
            7:       r = 33'sd8388437;
            8:       r = 33'sd4194283;
            9:       r = 33'sd2097149;
            10:      r = 33'sd1048576;
            11:      r = 33'sd524288;
            12:      r = 33'sd262144;
            13:      r = 33'sd131072;
            14:      r = 33'sd65536;
            15:      r = 33'sd32768;
            16:      r = 33'sd16384;
            17:      r = 33'sd8192;
            18:      r = 33'sd4096;
            19:      r = 33'sd2048;
            20:      r = 33'sd1024;
            21:      r = 33'sd512;
            22:      r = 33'sd256;
            23:      r = 33'sd128;
            default: r = 33'sd0;
        endcase
        return r;
    endfunction

    // Drop the 10 fraction bits, rounding toward zero.
    function automatic logic signed [X_W-11:0] trunc_px(input logic signed [X_W-1:0] v);
        logic signed [X_W-1:0] m;
        logic signed [X_W-1:0] t;
        m = -v;
        if (v[X_W-1])
            t = -(m >>> 10);
        else
            t = v >>> 10;
        return t[X_W-11:0];
    endfunction

endpackage

@@ hw/rtl/lpp_cordic_stage.sv @@
// One registered rotation-mode CORDIC iteration.
module lpp_cordic_stage
    import lpp_pkg::*;
#(
    parameter int SHIFT = 0
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  cordic_t din,
    output cordic_t dout
);

    localparam logic signed [Z_W-1:0] ATAN = atan_q30(SHIFT);

    cordic_t               dout_reg;
    cordic_t               dout_next;
    logic signed [X_W-1:0] xs;
    logic signed [X_W-1:0] ys;

    always_comb
    begin
        xs        = din.x >>> SHIFT;
        ys        = din.y >>> SHIFT;
        dout_next = din;
        if (!din.z[Z_W-1])
        begin
            dout_next.x = din.x - ys;
            dout_next.y = din.y + xs;
            dout_next.z = din.z - ATAN;
        end
        else
        begin
            dout_next.x = din.x + ys;
            dout_next.y = din.y - xs;
            dout_next.z = din.z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_reg <= '0;
        end
        else if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

@@ hw/rtl/lidar_polar_to_pixel.sv @@
// Top level of the polar-to-pixel converter for range-scanner nodes.
//
// Input channel (s_axis_*): one request per measurement node, carrying the
// quality byte, the raw angle word and the distance word in tdata and the
// scan-start flag in tuser. Output channel (m_axis_*): one request per node
// with non-zero distance, carrying saturated pixel x and y and the 6-bit
// quality in tdata and the scan-start flag in tuser. Nodes with zero
// distance are taken in and silently dropped.
// The pipeline has one stage for the distance-times-scale product and angle
// reduction, one for the gain multiply, one to load the CORDIC, one per
// CORDIC iteration, and one for quadrant mapping, centring and saturation
// into the output register.
// Throughput is one node per cycle when not stalled; every stage is a plain
// register with no feedback. The configuration port writes pixel_scale,
// centre_x and centre_y; it must only be used while the pipeline is empty.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready drops in the same cycle, so nothing is lost or repeated.
// Reset empties the pipeline and loads the register defaults.
module lidar_polar_to_pixel
    import lpp_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int COORD_BITS    = COORD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] raw quality byte, [23:8] angle_word, [39:24] distance_word
    input  logic [39:0] s_axis_tdata,
    // [0] scan_start
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] point_x, [31:16] point_y, [37:32] quality, [39:38] zero
    output logic [39:0] m_axis_tdata,
    // [0] starts_scan
    output logic        m_axis_tuser,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int NUM_ST   = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
    localparam int SAT_BITS = (COORD_BITS > 16) ? 16 : COORD_BITS;
    localparam logic signed [27:0] SAT_HI = 28'((64'sd1 <<< (SAT_BITS - 1)) - 1);
    localparam logic signed [27:0] SAT_LO = -SAT_HI - 28'sd1;

    // Configuration registers.
    logic [23:0] pixel_scale_reg;
    logic [11:0] centre_x_reg;
    logic [11:0] centre_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_scale_reg <= SCALE_RESET;
            centre_x_reg    <= CENTRE_X_RST;
            centre_y_reg    <= CENTRE_Y_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PIXEL_SCALE: pixel_scale_reg <= cfg_data;
                REG_CENTRE_X:    centre_x_reg    <= cfg_data[11:0];
                REG_CENTRE_Y:    centre_y_reg    <= cfg_data[11:0];
                default:         ; // unknown index: write ignored
            endcase
        end
    end

    // The whole pipeline moves together whenever the output slot can take
    // a new value; bubbles travel as invalid slots.
    logic adv;
    logic m_valid_reg;

    assign adv           = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    logic [7:0]  in_qual;
    logic [15:0] in_angle;
    logic [15:0] in_dist;
    logic        s_accept;

    assign in_qual  = s_axis_tdata[7:0];
    assign in_angle = s_axis_tdata[23:8];
    assign in_dist  = s_axis_tdata[39:24];
    assign s_accept = s_axis_tvalid && s_axis_tready;

    // Stage 0: angle reduction into quadrant and remainder, radius product.
    logic [14:0] ang_raw;
    logic [14:0] ang_red;
    quad_t       quad_next;
    logic [14:0] rem_wide;

    always_comb
    begin
        ang_raw = in_angle[15:1];
        ang_red = (ang_raw >= ANG_FULL) ? (ang_raw - ANG_FULL) : ang_raw;
        if (ang_red >= ANG_3QUARTER)
        begin
            quad_next = QUAD_3;
            rem_wide  = ang_red - ANG_3QUARTER;
        end
        else if (ang_red >= ANG_HALF)
        begin
            quad_next = QUAD_2;
            rem_wide  = ang_red - ANG_HALF;
        end
        else if (ang_red >= ANG_QUARTER)
        begin
            quad_next = QUAD_1;
            rem_wide  = ang_red - ANG_QUARTER;
        end
        else
        begin
            quad_next = QUAD_0;
            rem_wide  = ang_red;
        end
    end

    logic        s0_valid_reg;
    logic [39:0] s0_prod_reg;
    quad_t       s0_quad_reg;
    logic [12:0] s0_rem_reg;
    logic [5:0]  s0_qual_reg;
    logic        s0_start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= s_accept && (in_dist != 16'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_prod_reg  <= 40'(in_dist) * 40'(pixel_scale_reg);
            s0_quad_reg  <= quad_next;
            s0_rem_reg   <= rem_wide[12:0];
            s0_qual_reg  <= in_qual[7:2];
            s0_start_reg <= s_axis_tuser;
        end
    end

    // Stage 1: radius times inverse CORDIC gain, remainder to radians.
    logic                  s1_valid_reg;
    logic [61:0]           s1_xprod_reg;
    logic [31:0]           s1_z_reg;
    quad_t                 s1_quad_reg;
    logic [5:0]            s1_qual_reg;
    logic                  s1_start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_xprod_reg <= 62'(s0_prod_reg[39:8]) * 62'(INV_GAIN);
            s1_z_reg     <= 32'(s0_rem_reg) * ANG_TO_RAD;
            s1_quad_reg  <= s0_quad_reg;
            s1_qual_reg  <= s0_qual_reg;
            s1_start_reg <= s0_start_reg;
        end
    end

    // Stage 2: CORDIC start vector.
    cordic_t pipe [0:NUM_ST];
    cordic_t s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else if (adv)
        begin
            s2_reg.valid <= s1_valid_reg;
            s2_reg.x     <= $signed({4'b0000, s1_xprod_reg[61:30]});
            s2_reg.y     <= '0;
            s2_reg.z     <= $signed({1'b0, s1_z_reg});
            s2_reg.quad  <= s1_quad_reg;
            s2_reg.qual  <= s1_qual_reg;
            s2_reg.start <= s1_start_reg;
        end
    end

    assign pipe[0] = s2_reg;

    // CORDIC iterations, one register stage each.
    for (genvar g = 0; g < NUM_ST; g++)
    begin : g_cordic
        lpp_cordic_stage #(
            .SHIFT (g)
        ) u_stage (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (adv),
            .din   (pipe[g]),
            .dout  (pipe[g + 1])
        );
    end

    // Final stage: quadrant mapping, truncation, centring, saturation.
    cordic_t               last;
    logic signed [X_W-1:0] sn;
    logic signed [X_W-1:0] ncs;
    logic signed [27:0]    px_sum;
    logic signed [27:0]    py_sum;
    logic [15:0]           px_sat;
    logic [15:0]           py_sat;

    assign last = pipe[NUM_ST];

    always_comb
    begin
        case (last.quad)
            QUAD_0:
            begin
                sn  = last.y;
                ncs = -last.x;
            end
            QUAD_1:
            begin
                sn  = last.x;
                ncs = last.y;
            end
            QUAD_2:
            begin
                sn  = -last.y;
                ncs = last.x;
            end
            default:
            begin
                sn  = -last.x;
                ncs = -last.y;
            end
        endcase
        px_sum = 28'(trunc_px(sn)) + $signed({16'd0, centre_x_reg});
        py_sum = 28'(trunc_px(ncs)) + $signed({16'd0, centre_y_reg});
        if (px_sum > SAT_HI)
            px_sat = SAT_HI[15:0];
        else if (px_sum < SAT_LO)
            px_sat = SAT_LO[15:0];
        else
            px_sat = px_sum[15:0];
        if (py_sum > SAT_HI)
            py_sat = SAT_HI[15:0];
        else if (py_sum < SAT_LO)
            py_sat = SAT_LO[15:0];
        else
            py_sat = py_sum[15:0];
    end

    logic [15:0] px_reg;
    logic [15:0] py_reg;
    logic [5:0]  qual_reg;
    logic        start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg    <= px_sat;
            py_reg    <= py_sat;
            qual_reg  <= last.qual;
            start_reg <= last.start;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, qual_reg, py_reg, px_reg};
    assign m_axis_tuser  = start_reg;

    // A zero-distance node must never occupy a pipeline slot.
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && in_dist == 16'd0) |=> !s0_valid_reg)
        else $error("zero-distance node entered the pipeline");

    // Every accepted node with a distance occupies the first slot.
    a_keep_node: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && in_dist != 16'd0) |=> s0_valid_reg)
        else $error("accepted node was lost at the pipeline entry");

    // While the output is stalled, the first slot holds its contents.
    a_hold_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_axis_tready) |=> $stable(s0_valid_reg))
        else $error("pipeline moved during an output stall");

    // The CORDIC start angle always lies in the first quadrant.
    a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (s1_z_reg < 32'd1686629680))
        else $error("CORDIC start angle out of range");

endmodule

@@ verif/tb_lidar_polar_to_pixel.sv @@
// Self-checking testbench for the lidar polar-to-pixel converter.
module tb_lidar_polar_to_pixel;
    import lpp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One measurement node as it enters the converter.
    typedef struct {
        logic [7:0]  qual_byte;
        logic [15:0] angle;
        logic [15:0] distance;
        logic        start;
    } node_t;

    // One expected pixel result.
    typedef struct {
        logic [15:0] px;
        logic [15:0] py;
        logic [5:0]  qual;
        logic        start;
    } pixel_t;

    localparam int STAGES   = CORDIC_STAGES_DEF;
    localparam int LATENCY  = STAGES + 4;
    localparam int MAX_CYC  = 400000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    lidar_polar_to_pixel uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Shadow copy of the configuration registers used by the predictor.
    logic [23:0] scale_sh;
    logic [11:0] cx_sh;
    logic [11:0] cy_sh;

    node_t  node_q[$];     // nodes waiting to be sent
    pixel_t pixel_q[$];    // pixels expected from the converter
    int     n_err;
    int     n_sent;
    int     n_pixels;
    int     n_dropped;
    int     cycle;
    bit     hold_send;     // set to freeze the sender

    // Bit-true polar-to-pixel prediction with the fixed-point CORDIC.
    function automatic logic signed [63:0] atan_entry(input int i);
        logic signed [63:0] tbl [0:23];
        tbl = '{64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
                64'sd67021687, 64'sd33543516, 64'sd16775851, 64'sd8388437,
                64'sd4194283, 64'sd2097149, 64'sd1048576, 64'sd524288,
                64'sd262144, 64'sd131072, 64'sd65536, 64'sd32768,
                64'sd16384, 64'sd8192, 64'sd4096, 64'sd2048,
                64'sd1024, 64'sd512, 64'sd256, 64'sd128};
        return tbl[i];
    endfunction

    function automatic logic signed [63:0] drop_frac(input logic signed [63:0] v);
        if (v < 0)
            return -((-v) >>> 10);
        return v >>> 10;
    endfunction

    function automatic logic [15:0] clamp16(input logic signed [63:0] v);
        if (v > 64'sd32767)
            v = 64'sd32767;
        if (v < -64'sd32768)
            v = -64'sd32768;
        return v[15:0];
    endfunction

    function automatic pixel_t project_node(input node_t n);
        pixel_t             p;
        logic [14:0]        a;
        logic [1:0]         quad;
        logic [31:0]        r;
        logic [63:0]        rad;
        logic signed [63:0] x, y, z, xs, ys, sn, cs;
        a = n.angle[15:1];
        if (a >= ANG_FULL)
            a = a - ANG_FULL;
        quad = 2'(a / ANG_QUARTER);
        r = a - quad * ANG_QUARTER;
        rad = (64'(n.distance) * 64'(scale_sh)) >> 8;
        x = $signed((rad * 64'(INV_GAIN)) >> 30);
        y = 0;
        z = $signed(64'(r) * 64'd292818);
        for (int i = 0; i < STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_entry(i);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_entry(i);
            end
        end
        case (quad_t'(quad))
            QUAD_0:  begin sn = y;  cs = x;  end
            QUAD_1:  begin sn = x;  cs = -y; end
            QUAD_2:  begin sn = -y; cs = -x; end
            default: begin sn = -x; cs = y;  end
        endcase
        p.px = clamp16(drop_frac(sn) + 64'(cx_sh));
        p.py = clamp16(drop_frac(-cs) + 64'(cy_sh));
        p.qual = n.qual_byte[7:2];
        p.start = n.start;
        return p;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        n_err++;
        if (n_err <= 30)
            $display("MISMATCH @%0d %s: got %0h want %0h", cycle, what, got, want);
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            burst_left    <= 0;
            gap_left      <= 0;
        end
        else
        begin
            automatic bit fire = s_axis_tvalid && s_axis_tready;
            automatic bit can_load = !s_axis_tvalid || fire;
            if (fire)
            begin
                // The request just taken updates the expectations right away.
                automatic node_t n;
                n.qual_byte = s_axis_tdata[7:0];
                n.angle     = s_axis_tdata[23:8];
                n.distance  = s_axis_tdata[39:24];
                n.start     = s_axis_tuser;
                n_sent++;
                if (n.distance != 0)
                    pixel_q = {pixel_q, project_node(n)};
                else
                    n_dropped++;
            end
            if (can_load)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (node_q.size() > 0 && !hold_send)
                begin
                    automatic node_t n = node_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {n.distance, n.angle, n.qual_byte};
                    s_axis_tuser  <= n.start;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0
                                      : $urandom_range(0, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stalls in its own pattern, sometimes not at all for a while.
    int stall_mode;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_mode    <= 0;
        end
        else
        begin
            if ($urandom_range(0, 99) == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Monitor: compare each accepted pixel with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pixel_q.size() == 0)
            begin
                report_mismatch("unexpected pixel", m_axis_tdata[15:0], 16'd0);
            end
            else
            begin
                automatic pixel_t w = pixel_q.pop_front();
                n_pixels++;
                if (m_axis_tdata[15:0] !== w.px)
                    report_mismatch("point_x", m_axis_tdata[15:0], w.px);
                if (m_axis_tdata[31:16] !== w.py)
                    report_mismatch("point_y", m_axis_tdata[31:16], w.py);
                if (m_axis_tdata[37:32] !== w.qual)
                    report_mismatch("quality", 16'(m_axis_tdata[37:32]), 16'(w.qual));
                if (m_axis_tdata[39:38] !== 2'b00)
                    report_mismatch("pad bits", 16'(m_axis_tdata[39:38]), 16'd0);
                if (m_axis_tuser !== w.start)
                    report_mismatch("starts_scan", 16'(m_axis_tuser), 16'(w.start));
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYC)
        begin
            $display("timeout waiting for pixels");
            $display("tb_lidar_polar_to_pixel: done, errors");
            $finish;
        end
    end

    // Wait for the converter to drain, then pass its pipeline depth.
    task automatic wait_idle();
        while (node_q.size() > 0 || s_axis_tvalid || pixel_q.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_PIXEL_SCALE: scale_sh = val;
            REG_CENTRE_X:    cx_sh = val[11:0];
            default:         cy_sh = val[11:0];
        endcase
    endtask

    function automatic node_t random_node();
        node_t n;
        n.qual_byte = 8'($urandom_range(0, 255));
        // Mostly in-range angles, some above 360 degrees to hit the wrap.
        n.angle = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(46080, 65535))
                                              : 16'($urandom_range(0, 46079));
        case ($urandom_range(0, 9))
            0:       n.distance = 16'd0;
            1:       n.distance = 16'($urandom_range(1, 16));
            2:       n.distance = 16'hFFFF - 16'($urandom_range(0, 15));
            default: n.distance = 16'($urandom_range(1, 65535));
        endcase
        n.start = ($urandom_range(0, 15) == 0);
        return n;
    endfunction

    task automatic push_node(input logic [7:0] q, input logic [15:0] a,
                             input logic [15:0] d, input logic s);
        node_t n;
        n.qual_byte = q;
        n.angle = a;
        n.distance = d;
        n.start = s;
        node_q = {node_q, n};
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_PIXEL_SCALE;
        cfg_data = '0;
        cycle = 0;
        hold_send = 0;
        n_err = 0;
        n_sent = 0;
        n_pixels = 0;
        n_dropped = 0;
        scale_sh = SCALE_RESET;
        cx_sh = CENTRE_X_RST;
        cy_sh = CENTRE_Y_RST;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed nodes at reset defaults: quadrant edges, wrap, extremes,
        // dropped zero distance and the scan-start flag.
        push_node(8'hFF, 16'd0,     16'd4000,   1'b1);
        push_node(8'h00, 16'd11520, 16'd4000,   1'b0);
        push_node(8'h03, 16'd23040, 16'd4000,   1'b0);
        push_node(8'hFC, 16'd34560, 16'd4000,   1'b0);
        push_node(8'hA5, 16'd46079, 16'd4000,   1'b1);
        push_node(8'h5A, 16'd46080, 16'd4000,   1'b0);
        push_node(8'h80, 16'hFFFF,  16'd4000,   1'b0);
        push_node(8'h7F, 16'd1234,  16'd0,      1'b1);
        push_node(8'h40, 16'd5760,  16'd1,      1'b0);
        push_node(8'h10, 16'd9000,  16'hFFFF,   1'b1);
        push_node(8'h20, 16'd30000, 16'hFFFF,   1'b0);
        wait_idle();

        // Extreme configuration: huge scale saturates, zero scale collapses
        // every point onto the maximum centre.
        write_reg(REG_PIXEL_SCALE, 24'hFFFFFF);
        write_reg(REG_CENTRE_X, 24'd0);
        write_reg(REG_CENTRE_Y, 24'd4095);
        push_node(8'hFF, 16'd0,     16'hFFFF,   1'b0);
        push_node(8'h11, 16'd11520, 16'hFFFF,   1'b1);
        push_node(8'h22, 16'd23040, 16'hFFFF,   1'b0);
        push_node(8'h33, 16'd34560, 16'hFFFF,   1'b0);
        push_node(8'h44, 16'd7000,  16'd3,      1'b0);
        wait_idle();
        write_reg(REG_PIXEL_SCALE, 24'd0);
        write_reg(REG_CENTRE_X, 24'd4095);
        push_node(8'h55, 16'd7000,  16'd5000,   1'b1);
        push_node(8'h66, 16'd40000, 16'hFFFF,   1'b0);
        wait_idle();

        // Random phases, each with its own register setting.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       write_reg(REG_PIXEL_SCALE, SCALE_RESET);
                1:       write_reg(REG_PIXEL_SCALE, 24'd4096);
                2:       write_reg(REG_PIXEL_SCALE, 24'hFFFFFF);
                default: write_reg(REG_PIXEL_SCALE, 24'($urandom_range(0, 24'hFFFFFF)));
            endcase
            write_reg(REG_CENTRE_X, 24'($urandom_range(0, 4095)));
            write_reg(REG_CENTRE_Y, 24'($urandom_range(0, 4095)));
            for (int k = 0; k < 150; k++)
                node_q = {node_q, random_node()};
            // Midway, hold the sender until every pending pixel has come out.
            if (ph == 3)
            begin
                while (node_q.size() > 75)
                    @(posedge clk);
                hold_send = 1;
                while (s_axis_tvalid || pixel_q.size() > 0)
                    @(posedge clk);
                hold_send = 0;
            end
            wait_idle();
        end

        $display("Sent %0d nodes (%0d dropped), checked %0d pixels,", n_sent,
                 n_dropped, n_pixels);
        $display("across quadrants, angle wrap, saturation and nine settings.");
        if (n_err == 0)
            $display("tb_lidar_polar_to_pixel: done, clean");
        else
            $display("tb_lidar_polar_to_pixel: done, errors");
        $finish;
    end

endmodule
